// ===== rtl/core/bpc_pkg.sv =====
// Shared types and constants for the barometric pressure compensation unit.
`timescale 1ns / 1ps
package bpc_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned UpW   = 19;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_COMP = 1'b1;

  typedef enum logic [3:0] {
    IDX_AC1 = 4'd0,
    IDX_AC2 = 4'd1,
    IDX_AC3 = 4'd2,
    IDX_AC4 = 4'd3,
    IDX_AC5 = 4'd4,
    IDX_AC6 = 4'd5,
    IDX_B1  = 4'd6,
    IDX_B2  = 4'd7,
    IDX_MB  = 4'd8,
    IDX_MC  = 4'd9,
    IDX_MD  = 4'd10
  } coef_idx_e;

  localparam logic signed [31:0] B6Offset  = 32'sd4000;
  localparam logic signed [31:0] PolyA     = 32'sd3038;
  localparam logic signed [31:0] PolyB     = -32'sd7357;
  localparam logic signed [31:0] PolyC     = 32'sd3791;
  localparam logic [31:0]        B7Scale   = 32'd50000;
  localparam logic [31:0]        B4Bias    = 32'd32768;
  localparam logic [31:0]        SignBit   = 32'h8000_0000;
  localparam logic signed [31:0] B3Round   = 32'sd2;
  localparam logic signed [31:0] TRound    = 32'sd8;
  localparam logic signed [31:0] TMax      = 32'sd32767;
  localparam logic signed [31:0] TMin      = -32'sd32768;
  localparam logic signed [31:0] PMax      = 32'sd1048575;

  typedef struct packed {
    logic                      kind;
    logic [3:0]                coefficient_index;
    logic [15:0]               coefficient_word;
    logic [15:0]               raw_temperature;
    logic [23:0]               raw_pressure_bytes;
  } in_beat_t;

  typedef struct packed {
    logic signed [15:0]        temperature_tenths;
    logic [19:0]               pressure_pascal;
    logic                      status;
  } out_beat_t;

  typedef struct packed {
    logic signed [15:0]        ac1;
    logic signed [15:0]        ac2;
    logic signed [15:0]        ac3;
    logic [15:0]               ac4;
    logic [15:0]               ac5;
    logic [15:0]               ac6;
    logic signed [15:0]        b1;
    logic signed [15:0]        b2;
    logic signed [15:0]        mc;
    logic signed [15:0]        md;
  } cal_t;

  // fields that ride along the whole datapath
  typedef struct packed {
    cal_t                      cal;
    logic [UpW-1:0]            up;
    logic signed [15:0]        t;
    logic                      dz;
  } carry_t;

  typedef struct packed {
    logic signed [31:0]        x1;
    logic                      neg;
    carry_t                    c;
  } tside_t;

  typedef struct packed {
    logic                      dbl;
    carry_t                    c;
  } pside_t;

endpackage

// ===== rtl/core/bpc_stream_if.sv =====
// Valid/ready stream interface carrying one payload beat.
`timescale 1ns / 1ps
interface bpc_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/bpc_cal_store.sv =====
// Calibration word store with per-word sign handling.
`timescale 1ns / 1ps
module bpc_cal_store (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [3:0]          idx_i,
  input  logic [15:0]         word_i,
  output bpc_pkg::cal_t       cal_o
);
  import bpc_pkg::*;

  cal_t cal_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      unique case (idx_i)
        IDX_AC1: cal_q.ac1 <= word_i;
        IDX_AC2: cal_q.ac2 <= word_i;
        IDX_AC3: cal_q.ac3 <= word_i;
        IDX_AC4: cal_q.ac4 <= word_i;
        IDX_AC5: cal_q.ac5 <= word_i;
        IDX_AC6: cal_q.ac6 <= word_i;
        IDX_B1:  cal_q.b1  <= word_i;
        IDX_B2:  cal_q.b2  <= word_i;
        IDX_MB:  ; // not stored here, unused by the math
        IDX_MC:  cal_q.mc  <= word_i;
        IDX_MD:  cal_q.md  <= word_i;
        default: ; // out-of-range index dropped
      endcase
    end
  end

  assign cal_o = cal_q;
endmodule

// ===== rtl/core/bpc_div_pipe.sv =====
// Pipelined unsigned restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
module bpc_div_pipe #(
  parameter type SideT = logic
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [bpc_pkg::DataW-1:0]   dividend_i,
  input  logic [bpc_pkg::DataW-1:0]   divisor_i,
  input  SideT                        side_i,
  output logic                        valid_o,
  output logic [bpc_pkg::DataW-1:0]   quotient_o,
  output SideT                        side_o
);
  import bpc_pkg::*;

  localparam int unsigned N = DataW;

  logic [N:1]   v_q;
  logic [N-1:0] rem_q  [1:N];
  logic [N-1:0] num_q  [1:N];
  logic [N-1:0] den_q  [1:N];
  SideT         side_q [1:N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic         v_in;
    logic [N-1:0] r_in, n_in, d_in;
    SideT         s_in;
    logic [N:0]   sh, diff;
    logic         ge;

    if (k == 0) begin : g_first
      assign v_in = valid_i;
      assign r_in = '0;
      assign n_in = dividend_i;
      assign d_in = divisor_i;
      assign s_in = side_i;
    end else begin : g_next
      assign v_in = v_q[k];
      assign r_in = rem_q[k];
      assign n_in = num_q[k];
      assign d_in = den_q[k];
      assign s_in = side_q[k];
    end

    assign sh   = {r_in, n_in[N-1]};
    assign diff = sh - {1'b0, d_in};
    assign ge   = (sh >= {1'b0, d_in});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else if (en_i) begin
        v_q[k+1] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1]  <= ge ? diff[N-1:0] : sh[N-1:0];
        num_q[k+1]  <= {n_in[N-2:0], ge};
        den_q[k+1]  <= d_in;
        side_q[k+1] <= s_in;
      end
    end
  end

  assign valid_o    = v_q[N];
  assign quotient_o = num_q[N];
  assign side_o     = side_q[N];
endmodule

// ===== rtl/core/barometric_pressure_compensation_unit.sv =====
// Top level of the barometric pressure and temperature compensation unit.
// Two 32-stage dividers lie on the path from input beat to result beat.
// Accepts one compensate or load beat per cycle unless the output beat is stalled; load beats give no result.
// The whole pipeline moves on one enable; it holds while the output beat waits.
// Reset clears valid bits and sets oversampling to 1; calibration words must be loaded.
`timescale 1ns / 1ps
module barometric_pressure_compensation_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  bpc_stream_if.sink    in_i,
  bpc_stream_if.source  out_o,
  bpc_stream_if.sink    cfg_i
);
  import bpc_pkg::*;

  // ---------------------------------------------------------------- control
  logic      en;            // pipeline advance
  logic      out_v_q;
  out_beat_t out_q;
  logic      in_acc, comp_acc;
  logic [1:0] oss_q;
  in_beat_t  ib;
  cal_t      cal;

  assign en          = !out_v_q || out_o.ready;
  assign in_i.ready  = en;
  assign ib          = in_i.data;
  assign in_acc      = in_i.valid && en;
  assign comp_acc    = in_acc && (ib.kind == KIND_COMP);

  // config: oversampling setting, always accepted
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oss_q <= 2'd1;
    end else if (cfg_i.valid) begin
      oss_q <= cfg_i.data;
    end
  end

  bpc_cal_store u_cal (
    .clk_i  (clk_i),
    .we_i   (in_acc && (ib.kind == KIND_LOAD)),
    .idx_i  (ib.coefficient_index),
    .word_i (ib.coefficient_word),
    .cal_o  (cal)
  );

  // ------------------------------------------------------- temperature front
  // s1: UT - AC6, UP alignment; coefficients are snapshot with the beat
  logic               v1_q;
  logic signed [31:0] a1_q;
  carry_t             c1_q, c1_d;
  logic [3:0]         up_sh;

  assign up_sh     = 4'd8 - {2'b00, oss_q};
  always_comb begin
    c1_d     = '0;
    c1_d.cal = cal;
    c1_d.up  = UpW'(ib.raw_pressure_bytes >> up_sh);
  end

  // s2: (UT - AC6) * AC5
  logic        v2_q;
  logic [31:0] m2_q;
  carry_t      c2_q;

  // s3: X1 and the divisor X1 + MD
  logic               v3_q;
  logic signed [31:0] x1_3_q, dv3_q, x1_3_d, dv3_d;
  carry_t             c3_q;

  assign x1_3_d = $signed(m2_q) >>> 15;
  assign dv3_d  = x1_3_d + 32'(c2_q.cal.md);

  // s4: magnitudes for the signed quotient MC*2^11 / (X1 + MD)
  logic               v4_q;
  logic [31:0]        nm4_q, dm4_q;
  tside_t             ts4_q, ts4_d;
  logic signed [31:0] mc_sh;

  assign mc_sh = 32'(c3_q.cal.mc) <<< 11;
  always_comb begin
    ts4_d      = '0;
    ts4_d.x1   = x1_3_q;
    ts4_d.neg  = mc_sh[31] ^ dv3_q[31];
    ts4_d.c    = c3_q;
    ts4_d.c.dz = (dv3_q == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en) begin
      v1_q <= comp_acc;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a1_q   <= $signed({16'd0, ib.raw_temperature}) - $signed({16'd0, cal.ac6});
      c1_q   <= c1_d;
      m2_q   <= 32'(a1_q) * {16'd0, c1_q.cal.ac5};
      c2_q   <= c1_q;
      x1_3_q <= x1_3_d;
      dv3_q  <= dv3_d;
      c3_q   <= c2_q;
      nm4_q  <= mc_sh[31] ? (32'd0 - 32'(mc_sh)) : 32'(mc_sh);
      dm4_q  <= dv3_q[31] ? (32'd0 - 32'(dv3_q)) : 32'(dv3_q);
      ts4_q  <= ts4_d;
    end
  end

  logic        vd1;
  logic [31:0] qd1;
  tside_t      tsd1;

  bpc_div_pipe #(.SideT(tside_t)) u_div_t (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (v4_q),
    .dividend_i (nm4_q),
    .divisor_i  (dm4_q),
    .side_i     (ts4_q),
    .valid_o    (vd1),
    .quotient_o (qd1),
    .side_o     (tsd1)
  );

  // ------------------------------------------------------------ pressure mid
  // s5: B5 = X1 + X2
  logic               v5_q;
  logic signed [31:0] b5_q;
  carry_t             c5_q;
  logic [31:0]        x2_5;
  assign x2_5 = tsd1.neg ? (32'd0 - qd1) : qd1;

  // s6: temperature out, B6
  logic               v6_q;
  logic signed [31:0] b6_q, t6;
  carry_t             c6_q, c6_d;
  assign t6 = (b5_q + TRound) >>> 4;
  always_comb begin
    c6_d = c5_q;
    if (t6 > TMax) begin
      c6_d.t = 16'sh7fff;
    end else if (t6 < TMin) begin
      c6_d.t = 16'sh8000;
    end else begin
      c6_d.t = t6[15:0];
    end
  end

  // s7: B6*B6, AC2*B6, AC3*B6
  logic               v7_q;
  logic signed [31:0] pbb7_q, pa2_7_q, pa3_7_q;
  carry_t             c7_q;

  // s8: B2*sq, B1*sq
  logic               v8_q;
  logic signed [31:0] sq8, pb2_8_q, pb1_8_q, x2a8_q, x1c8_q;
  carry_t             c8_q;
  assign sq8 = pbb7_q >>> 12;

  // s9: X3 for B3 and X3 for B4
  logic               v9_q;
  logic signed [31:0] x3a9_q, x3c9_q;
  carry_t             c9_q;

  // s10: B3 numerator, B4 product
  logic               v10_q;
  logic signed [31:0] n10_q, n10_d;
  logic [31:0]        b4p10_q;
  carry_t             c10_q;
  assign n10_d = (((32'(c9_q.cal.ac1) <<< 2) + x3a9_q) <<< oss_q) + B3Round;

  // s11: B3 = numerator / 4 truncated, B4
  logic               v11_q;
  logic signed [31:0] b3_11_q;
  logic [31:0]        b4_11_q;
  carry_t             c11_q;

  // s12: UP - B3
  logic               v12_q;
  logic [31:0]        upd12_q, b4_12_q;
  carry_t             c12_q;

  // s13: B7
  logic               v13_q;
  logic [31:0]        b7_13_q, b4_13_q;
  carry_t             c13_q;

  // s14: divider setup for B7 / B4
  logic               v14_q;
  logic [31:0]        nm14_q, dm14_q;
  pside_t             ps14_q, ps14_d;
  always_comb begin
    ps14_d      = '0;
    ps14_d.dbl  = (b7_13_q >= SignBit);
    ps14_d.c    = c13_q;
    ps14_d.c.dz = c13_q.dz || (b4_13_q == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q  <= 1'b0;
      v6_q  <= 1'b0;
      v7_q  <= 1'b0;
      v8_q  <= 1'b0;
      v9_q  <= 1'b0;
      v10_q <= 1'b0;
      v11_q <= 1'b0;
      v12_q <= 1'b0;
      v13_q <= 1'b0;
      v14_q <= 1'b0;
    end else if (en) begin
      v5_q  <= vd1;
      v6_q  <= v5_q;
      v7_q  <= v6_q;
      v8_q  <= v7_q;
      v9_q  <= v8_q;
      v10_q <= v9_q;
      v11_q <= v10_q;
      v12_q <= v11_q;
      v13_q <= v12_q;
      v14_q <= v13_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b5_q    <= tsd1.x1 + $signed(x2_5);
      c5_q    <= tsd1.c;
      b6_q    <= b5_q - B6Offset;
      c6_q    <= c6_d;
      pbb7_q  <= b6_q * b6_q;
      pa2_7_q <= b6_q * 32'(c6_q.cal.ac2);
      pa3_7_q <= b6_q * 32'(c6_q.cal.ac3);
      c7_q    <= c6_q;
      pb2_8_q <= sq8 * 32'(c7_q.cal.b2);
      pb1_8_q <= sq8 * 32'(c7_q.cal.b1);
      x2a8_q  <= pa2_7_q >>> 11;
      x1c8_q  <= pa3_7_q >>> 13;
      c8_q    <= c7_q;
      x3a9_q  <= (pb2_8_q >>> 11) + x2a8_q;
      x3c9_q  <= (x1c8_q + (pb1_8_q >>> 16) + B3Round) >>> 2;
      c9_q    <= c8_q;
      n10_q   <= n10_d;
      b4p10_q <= {16'd0, c9_q.cal.ac4} * (32'(x3c9_q) + B4Bias);
      c10_q   <= c9_q;
      b3_11_q <= (n10_q + (n10_q[31] ? 32'sd3 : 32'sd0)) >>> 2;
      b4_11_q <= b4p10_q >> 15;
      c11_q   <= c10_q;
      upd12_q <= {{(32-UpW){1'b0}}, c11_q.up} - 32'(b3_11_q);
      b4_12_q <= b4_11_q;
      c12_q   <= c11_q;
      b7_13_q <= upd12_q * (B7Scale >> oss_q);
      b4_13_q <= b4_12_q;
      c13_q   <= c12_q;
      nm14_q  <= (b7_13_q >= SignBit) ? b7_13_q : (b7_13_q << 1);
      dm14_q  <= b4_13_q;
      ps14_q  <= ps14_d;
    end
  end

  logic        vd2;
  logic [31:0] qd2;
  pside_t      psd2;

  bpc_div_pipe #(.SideT(pside_t)) u_div_p (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (v14_q),
    .dividend_i (nm14_q),
    .divisor_i  (dm14_q),
    .side_i     (ps14_q),
    .valid_o    (vd2),
    .quotient_o (qd2),
    .side_o     (psd2)
  );

  // ----------------------------------------------------------- pressure tail
  // s15: p from the quotient
  logic               v15_q;
  logic signed [31:0] p15_q, p8_15;
  carry_t             c15_q;
  assign p8_15 = p15_q >>> 8;

  // s16: (p>>8)^2 and -7357*p
  logic               v16_q;
  logic signed [31:0] sq16_q, m16_q, p16_q;
  carry_t             c16_q;

  // s17: *3038, X2
  logic               v17_q;
  logic signed [31:0] m17_q, x2_17_q, p17_q;
  carry_t             c17_q;

  // s18: final p
  logic               v18_q;
  logic signed [31:0] p18_q;
  carry_t             c18_q;

  out_beat_t ob_d;
  always_comb begin
    ob_d = '0;
    if (c18_q.dz) begin
      ob_d.status = 1'b1;
    end else begin
      ob_d.temperature_tenths = c18_q.t;
      if (p18_q[31]) begin
        ob_d.pressure_pascal = '0;
      end else if (p18_q > PMax) begin
        ob_d.pressure_pascal = PMax[19:0];
      end else begin
        ob_d.pressure_pascal = p18_q[19:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v15_q   <= 1'b0;
      v16_q   <= 1'b0;
      v17_q   <= 1'b0;
      v18_q   <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      v15_q   <= vd2;
      v16_q   <= v15_q;
      v17_q   <= v16_q;
      v18_q   <= v17_q;
      out_v_q <= v18_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p15_q   <= psd2.dbl ? $signed(qd2 << 1) : $signed(qd2);
      c15_q   <= psd2.c;
      sq16_q  <= p8_15 * p8_15;
      m16_q   <= p15_q * PolyB;
      p16_q   <= p15_q;
      c16_q   <= c15_q;
      m17_q   <= sq16_q * PolyA;
      x2_17_q <= m16_q >>> 16;
      p17_q   <= p16_q;
      c17_q   <= c16_q;
      p18_q   <= p17_q + (((m17_q >>> 16) + x2_17_q + PolyC) >>> 4);
      c18_q   <= c17_q;
      out_q   <= ob_d;
    end
  end

  assign out_o.valid = out_v_q;
  assign out_o.data  = out_q;
endmodule

// ===== sim/tb_barometric_pressure_compensation_unit.sv =====
// Self-checking testbench for the barometric pressure compensation unit.
`timescale 1ns / 1ps
module tb_barometric_pressure_compensation_unit;
  import bpc_pkg::*;

  localparam int unsigned WatchLimit = 5000;
  localparam int unsigned DrainCycles = 120;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  bpc_stream_if #(.T(in_beat_t))   in_if  ();
  bpc_stream_if #(.T(out_beat_t))  out_if ();
  bpc_stream_if #(.T(logic [1:0])) cfg_if ();

  barometric_pressure_compensation_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if.sink),
    .out_o  (out_if.source),
    .cfg_i  (cfg_if.sink)
  );

  // shadow of the block state
  logic [15:0] cal_words [11];
  logic [1:0]  oss_shadow;

  out_beat_t   pending_results [$];
  int          src_idle_pct;
  int          snk_idle_pct;
  int          mismatches;
  int          comp_beats;
  int          load_beats;
  int          zero_div_seen;
  int          idle_cycles;

  typedef struct {
    in_beat_t  beat;
    bit        typed;
    out_beat_t want;
  } stim_row_t;

  stim_row_t   stim_rows [$];

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [31:0] sx16(logic [15:0] w);
    return {{16{w[15]}}, w};
  endfunction

  function automatic logic [31:0] asr(logic [31:0] v, int n);
    return $signed(v) >>> n;
  endfunction

  // truncating signed divide, divisor nonzero; -2^31 / -1 wraps
  function automatic logic [31:0] sdiv(logic [31:0] a, logic [31:0] b);
    logic [31:0] ma, mb, q;
    ma = a[31] ? 32'd0 - a : a;
    mb = b[31] ? 32'd0 - b : b;
    q  = ma / mb;
    return (a[31] != b[31]) ? 32'd0 - q : q;
  endfunction

  function automatic out_beat_t compensate(in_beat_t b);
    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    logic [31:0] ut, up, x1, x2, x3, b3, b4, b5, b6, b7, p, dv, sq;
    int          t, ps;
    out_beat_t   r;
    r = '0;
    r.status = 1'b1;
    ac1 = sx16(cal_words[IDX_AC1]);
    ac2 = sx16(cal_words[IDX_AC2]);
    ac3 = sx16(cal_words[IDX_AC3]);
    ac4 = {16'd0, cal_words[IDX_AC4]};
    ac5 = {16'd0, cal_words[IDX_AC5]};
    ac6 = {16'd0, cal_words[IDX_AC6]};
    b1  = sx16(cal_words[IDX_B1]);
    b2  = sx16(cal_words[IDX_B2]);
    mc  = sx16(cal_words[IDX_MC]);
    md  = sx16(cal_words[IDX_MD]);
    ut  = {16'd0, b.raw_temperature};
    up  = {8'd0, b.raw_pressure_bytes} >> (4'd8 - oss_shadow);
    // temperature
    x1 = asr((ut - ac6) * ac5, 15);
    dv = x1 + md;
    if (dv == 0) return r;
    x2 = sdiv(mc << 11, dv);
    b5 = x1 + x2;
    t  = $signed(asr(b5 + TRound, 4));
    // pressure
    b6 = b5 - B6Offset;
    sq = asr(b6 * b6, 12);
    x1 = asr(b2 * sq, 11);
    x2 = asr(ac2 * b6, 11);
    x3 = x1 + x2;
    b3 = sdiv(((ac1 * 32'd4 + x3) << oss_shadow) + B3Round, 32'd4);
    x1 = asr(ac3 * b6, 13);
    x2 = asr(b1 * sq, 16);
    x3 = asr(x1 + x2 + 32'd2, 2);
    b4 = (ac4 * (x3 + B4Bias)) >> 15;
    b7 = (up - b3) * (B7Scale >> oss_shadow);
    if (b4 == 0) return r;
    if (b7 < SignBit) p = (b7 * 32'd2) / b4;
    else p = (b7 / b4) * 32'd2;
    x1 = asr(p, 8) * asr(p, 8);
    x1 = asr(x1 * PolyA, 16);
    x2 = asr(PolyB * p, 16);
    p  = p + asr(x1 + x2 + PolyC, 4);
    ps = $signed(p);
    if (t > TMax) t = TMax;
    if (t < TMin) t = TMin;
    if (ps < 0) ps = 0;
    if (ps > PMax) ps = PMax;
    r.temperature_tenths = t[15:0];
    r.pressure_pascal    = ps[19:0];
    r.status             = 1'b0;
    return r;
  endfunction

  function automatic in_beat_t load_beat(coef_idx_e idx, logic [15:0] w);
    in_beat_t b;
    b = '0;
    b.kind = KIND_LOAD;
    b.coefficient_index = idx;
    b.coefficient_word = w;
    return b;
  endfunction

  function automatic in_beat_t comp_beat(logic [15:0] ut, logic [23:0] raw);
    in_beat_t b;
    b = '0;
    b.kind = KIND_COMP;
    b.raw_temperature = ut;
    b.raw_pressure_bytes = raw;
    return b;
  endfunction

  task automatic add_row(in_beat_t b, bit typed = 1'b0, out_beat_t want = '0);
    stim_rows.push_back('{beat: b, typed: typed, want: want});
  endtask

  task automatic report_mismatch(string what, out_beat_t got, out_beat_t want);
    mismatches++;
    $display("MISMATCH %s: got t=%0d p=%0d s=%0d want t=%0d p=%0d s=%0d", what,
             got.temperature_tenths, got.pressure_pascal, got.status,
             want.temperature_tenths, want.pressure_pascal, want.status);
  endtask

  // one input beat; expected result taken at the accepting edge
  task automatic send_beat(in_beat_t b, bit typed = 1'b0, out_beat_t want = '0);
    if ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= b;
    do @(posedge clk_i); while (!in_if.ready);
    if (b.kind == KIND_COMP) begin
      pending_results.push_back(typed ? want : compensate(b));
      comp_beats++;
    end else begin
      load_beats++;
      if (b.coefficient_index <= IDX_MD) cal_words[b.coefficient_index] = b.coefficient_word;
    end
  endtask

  task automatic drain;
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    // load beats leave no result, so give the pipe time to empty
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_oss(logic [1:0] v);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= v;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    oss_shadow = v;
  endtask

  // result checker and receiver stalls
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected beat", out_if.data, '0);
        end else begin
          out_beat_t want;
          want = pending_results.pop_front();
          if (out_if.data.status == 1'b1) zero_div_seen++;
          if (out_if.data.temperature_tenths != want.temperature_tenths)
            report_mismatch("temperature", out_if.data, want);
          else if (out_if.data.pressure_pascal != want.pressure_pascal)
            report_mismatch("pressure", out_if.data, want);
          else if (out_if.data.status != want.status)
            report_mismatch("status", out_if.data, want);
        end
      end
      out_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchLimit) begin
      $display("timeout waiting for a beat");
      $display("tb_barometric_pressure_compensation_unit NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int ph;
    int n;
    int src_tab [4];
    int snk_tab [4];
    logic [1:0] oss_tab [4];
    in_beat_t b;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    out_if.ready = 1'b0;
    src_idle_pct = 0;
    snk_idle_pct = 0;
    mismatches = 0;
    comp_beats = 0;
    load_beats = 0;
    zero_div_seen = 0;
    idle_cycles = 0;
    oss_shadow = 2'd1;
    foreach (cal_words[i]) cal_words[i] = '0;
    src_tab = '{0, 59, 0, 24};
    snk_tab = '{0, 0, 59, 24};
    oss_tab = '{2'd0, 2'd3, 2'd2, 2'd1};

    // datasheet calibration set, mb at its negative extreme
    add_row(load_beat(IDX_AC1, 16'd408));
    add_row(load_beat(IDX_AC2, -16'sd72));
    add_row(load_beat(IDX_AC3, -16'sd14383));
    add_row(load_beat(IDX_AC4, 16'd32741));
    add_row(load_beat(IDX_AC5, 16'd32757));
    add_row(load_beat(IDX_AC6, 16'd23153));
    add_row(load_beat(IDX_B1, 16'd6190));
    add_row(load_beat(IDX_B2, 16'd4));
    add_row(load_beat(IDX_MB, 16'h8000));
    add_row(load_beat(IDX_MC, -16'sd8711));
    add_row(load_beat(IDX_MD, 16'd2868));
    // oversampling at its reset value here
    add_row(comp_beat(16'd27898, 24'd23843 << 7));
    add_row(comp_beat(16'h0000, 24'h000000));
    add_row(comp_beat(16'hFFFF, 24'hFFFFFF));
    add_row(comp_beat(16'hFFFF, 24'h000000));
    // out-of-range index is dropped
    b = load_beat(IDX_AC1, 16'hFFFF);
    b.coefficient_index = 4'hF;
    add_row(b);
    add_row(comp_beat(16'd27898, 24'h5D2300));
    // zero temperature divisor: ac5 and md both zero
    add_row(load_beat(IDX_AC5, 16'd0));
    add_row(load_beat(IDX_MD, 16'd0));
    add_row(comp_beat(16'd27898, 24'h5D2300), 1'b1, '{0, 0, 1'b1});
    add_row(load_beat(IDX_AC5, 16'd32757));
    add_row(load_beat(IDX_MD, 16'd2868));
    // zero pressure divisor: ac4 zero
    add_row(load_beat(IDX_AC4, 16'd0));
    add_row(comp_beat(16'd27898, 24'h5D2300), 1'b1, '{0, 0, 1'b1});
    add_row(load_beat(IDX_AC4, 16'hFFFF));

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stim_rows[i]) send_beat(stim_rows[i].beat, stim_rows[i].typed, stim_rows[i].want);
    drain();

    for (ph = 0; ph < 4; ph++) begin
      write_oss(oss_tab[ph]);
      src_idle_pct = src_tab[ph];
      snk_idle_pct = snk_tab[ph];
      for (n = 0; n < 200; n++) begin
        if ($urandom_range(99) < 15) begin
          b = load_beat(IDX_AC1, 16'($urandom));
          b.coefficient_index = 4'($urandom_range(15));
        end else begin
          b = comp_beat(16'($urandom), 24'($urandom));
        end
        send_beat(b);
      end
      drain();
    end

    $display("covered %0d compensate and %0d load beats, oversampling 0..3,", comp_beats,
             load_beats);
    $display("four stall patterns, %0d zero-divisor results", zero_div_seen);
    if (mismatches == 0) begin
      $display("tb_barometric_pressure_compensation_unit OK");
    end else begin
      $display("tb_barometric_pressure_compensation_unit NOT OK");
    end
    $finish;
  end

endmodule
